@@ design/gcp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gcp_pkg;

  localparam logic [31:0] F32_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F32_TWO      = 32'h4000_0000;
  localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [15:0] F16_QNAN     = 16'h7E00;
  localparam logic [15:0] F16_INF      = 16'h7C00;

  // Exact product or sum before normalization: value = mag * 2^texp.
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sign;
    logic [49:0]        mag;
    logic signed [12:0] texp;
  } unr_t;

  // Normalized value ready for the rounding increment.
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sign;
    logic [30:0] body;
    logic        guard;
    logic        sticky;
  } nrm_t;

  function automatic logic [31:0] f32_neg(input logic [31:0] a);
    return {~a[31], a[30:0]};
  endfunction

  function automatic unr_t fmul_front(input logic [31:0] a, input logic [31:0] b);
    unr_t u;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;
    logic [23:0] sig_a, sig_b;
    logic [47:0] prod;
    a_nan  = (&a[30:23]) & (|a[22:0]);
    b_nan  = (&b[30:23]) & (|b[22:0]);
    a_inf  = (&a[30:23]) & ~(|a[22:0]);
    b_inf  = (&b[30:23]) & ~(|b[22:0]);
    a_zero = ~(|a[30:0]);
    b_zero = ~(|b[30:0]);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    sig_a = {|a[30:23], a[22:0]};
    sig_b = {|b[30:23], b[22:0]};
    prod = 48'(sig_a) * 48'(sig_b);
    u.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    u.inf  = a_inf | b_inf;
    u.sign = a[31] ^ b[31];
    u.mag  = {2'b00, prod};
    u.texp = $signed({5'b0, ea}) + $signed({5'b0, eb}) - 13'sd300;
    return u;
  endfunction

  function automatic unr_t fadd_front(input logic [31:0] a, input logic [31:0] b);
    unr_t u;
    logic a_nan, b_nan, a_inf, b_inf;
    logic [7:0] ea, eb, hi_e, lo_e, d;
    logic [23:0] sig_a, sig_b, hi_sig, lo_sig;
    logic hi_s, lo_s;
    logic [4:0] dc;
    logic [31:0] xb, sh, mask;
    logic st;
    logic [27:0] xa, al, sum;
    logic sgn;
    a_nan = (&a[30:23]) & (|a[22:0]);
    b_nan = (&b[30:23]) & (|b[22:0]);
    a_inf = (&a[30:23]) & ~(|a[22:0]);
    b_inf = (&b[30:23]) & ~(|b[22:0]);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    sig_a = {|a[30:23], a[22:0]};
    sig_b = {|b[30:23], b[22:0]};
    if (ea >= eb) begin
      hi_e = ea; hi_sig = sig_a; hi_s = a[31];
      lo_e = eb; lo_sig = sig_b; lo_s = b[31];
    end else begin
      hi_e = eb; hi_sig = sig_b; hi_s = b[31];
      lo_e = ea; lo_sig = sig_a; lo_s = a[31];
    end
    d  = hi_e - lo_e;
    dc = (d > 8'd31) ? 5'd31 : d[4:0];
    // Three extra bits below the significand: guard, round and a sticky bit.
    xb   = {5'b0, lo_sig, 3'b000};
    sh   = xb >> dc;
    mask = (32'd1 << dc) - 32'd1;
    st   = |(xb & mask);
    al   = {1'b0, sh[26:1], sh[0] | st};
    xa   = {1'b0, hi_sig, 3'b000};
    if (hi_s == lo_s) begin
      sum = xa + al;
      sgn = hi_s;
    end else if (xa >= al) begin
      sum = xa - al;
      sgn = hi_s;
    end else begin
      sum = al - xa;
      sgn = lo_s;
    end
    // An exact zero sum is negative only when both operands are negative.
    if (sum == 28'd0) begin
      sgn = a[31] & b[31];
    end
    u.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    u.inf  = a_inf | b_inf;
    u.sign = a_inf ? a[31] : (b_inf ? b[31] : sgn);
    u.mag  = {22'b0, sum};
    u.texp = $signed({5'b0, hi_e}) - 13'sd153;
    return u;
  endfunction

  function automatic nrm_t fnorm(input unr_t u);
    nrm_t n;
    logic [5:0] p;
    logic signed [12:0] be, q, sq;
    logic [6:0] s;
    logic [75:0] z, r, mask, half, rem;
    logic zero;
    p = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (u.mag[i]) begin
        p = 6'(i);
      end
    end
    zero = (u.mag == 50'd0);
    be = $signed({7'b0, p}) + u.texp + 13'sd127;
    // Below the normal range the LSB is pinned at the subnormal weight.
    if (be >= 13'sd1) begin
      q = $signed({7'b0, p}) - 13'sd23;
    end else begin
      q = -13'sd149 - u.texp;
    end
    sq = q + 13'sd26;
    s  = (sq > 13'sd77) ? 7'd77 : sq[6:0];
    z    = {u.mag, 26'b0};
    r    = z >> s;
    mask = (76'd1 << s) - 76'd1;
    half = 76'd1 << (s - 7'd1);
    rem  = z & mask;
    n.nan  = u.nan;
    n.inf  = u.inf | (~zero & (be >= 13'sd255));
    n.sign = u.sign;
    if (zero) begin
      n.body = 31'd0;
    end else if (be >= 13'sd1) begin
      n.body = {be[7:0], r[22:0]};
    end else begin
      n.body = {8'd0, r[22:0]};
    end
    n.guard  = ~zero & (|(rem & half));
    n.sticky = ~zero & (|(rem & (half - 76'd1)));
    return n;
  endfunction

  function automatic logic [31:0] fround(input nrm_t n);
    logic inc;
    logic [30:0] body;
    inc  = n.guard & (n.sticky | n.body[0]);
    // A carry out of the fraction moves the exponent up, up to infinity.
    body = n.body + {30'd0, inc};
    if (n.nan) begin
      return F32_QNAN;
    end else if (n.inf) begin
      return {n.sign, 8'hFF, 23'd0};
    end
    return {n.sign, body};
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic [15:0] sgn;
    logic [7:0] ex;
    logic [22:0] man;
    logic signed [9:0] e, shv;
    logic [4:0] sh;
    logic [23:0] m, r, rem, hw;
    logic [14:0] h;
    logic [12:0] rl;
    sgn = {f[31], 15'd0};
    ex  = f[30:23];
    man = f[22:0];
    e   = $signed({2'b0, ex}) - 10'sd112;
    shv = 10'sd14 - e;
    sh  = shv[4:0];
    m   = {1'b1, man};
    r   = m >> sh;
    rem = m & ((24'd1 << sh) - 24'd1);
    hw  = 24'd1 << (sh - 5'd1);
    h   = {e[4:0], man[22:13]};
    rl  = man[12:0];
    if (ex == 8'hFF) begin
      return (man != 23'd0) ? F16_QNAN : (sgn | F16_INF);
    end
    if (e >= 10'sd31) begin
      return sgn | F16_INF;
    end
    if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        return sgn;
      end
      if ((rem > hw) || ((rem == hw) && r[0])) begin
        r = r + 24'd1;
      end
      return sgn | r[15:0];
    end
    if ((rl > 13'h1000) || ((rl == 13'h1000) && h[0])) begin
      h = h + 15'd1;
    end
    return sgn | {1'b0, h};
  endfunction

endpackage
`default_nettype wire

@@ design/gcp_fmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gcp_fmul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);
  import gcp_pkg::*;

  unr_t u;
  nrm_t n;

  // Three stages: significand product, normalize shift, rounding.
  always_ff @(posedge clk) begin
    u <= fmul_front(a, b);
    n <= fnorm(u);
    y <= fround(n);
  end

endmodule
`default_nettype wire

@@ design/gcp_fadd.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gcp_fadd (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);
  import gcp_pkg::*;

  unr_t u;
  nrm_t n;

  // Three stages: align and add, normalize shift, rounding.
  always_ff @(posedge clk) begin
    u <= fadd_front(a, b);
    n <= fnorm(u);
    y <= fround(n);
  end

endmodule
`default_nettype wire

@@ design/gaussian_covariance_packer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Splat record packer: builds the 3D covariance of a splat from its scale and
// rotation quaternion and packs it as six half-precision terms.
// Input: a record transfer happens on a clock edge where start is high and
// busy is low. busy is always low, so a record can be sent on every cycle.
// Output: done is high for one cycle with the packed record on the result
// ports; the receiver must take it in that cycle and cannot hold it off.
// The throughput is one record per cycle. The path is eight levels of
// single-precision multiply or add units, each three stages deep
// (operand setup and multiply or align, normalize shift, rounding), followed
// by one stage of half conversion and packing.
// Position and color bits travel beside the math in a delay line.
// Synchronous reset clears the valid bits of the pipeline, so no done pulse
// appears for records in flight at reset; data registers are not reset.
module gaussian_covariance_packer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] scale_x,
  input  wire logic [31:0] scale_y,
  input  wire logic [31:0] scale_z,
  input  wire logic [31:0] rot_w,
  input  wire logic [31:0] rot_x,
  input  wire logic [31:0] rot_y,
  input  wire logic [31:0] rot_z,
  input  wire logic [31:0] color_rgba,
  output logic             done,
  output logic      [31:0] word_pos_x,
  output logic      [31:0] word_pos_y,
  output logic      [31:0] word_pos_z,
  output logic             selection_word,
  output logic      [31:0] cov_xx_xy,
  output logic      [31:0] cov_xz_yy,
  output logic      [31:0] cov_yz_zz,
  output logic      [31:0] packed_color
);
  import gcp_pkg::*;

  localparam int Latency = 25;
  localparam int ScaleTap = 12;
  localparam int TermI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int TermJ [6] = '{0, 1, 2, 1, 2, 2};

  logic [Latency-1:0] vld;
  logic [127:0] pass [Latency];
  logic [95:0] scl [ScaleTap];

  logic [31:0] l1a [9], l1b [9], l1 [9];
  logic [31:0] l2a [9], l2b [9], l2 [9];
  logic [31:0] l3 [9];
  logic [31:0] l4a [9], l4b [9], l4 [9];
  logic [31:0] l5b [9], l5 [9];
  logic [31:0] l6a [18], l6b [18], l6 [18];
  logic [31:0] l7a [6], l7b [6], l7 [6];
  logic [31:0] pd0 [6], pd1 [6], pd2 [6];
  logic [31:0] l8 [6];

  assign busy = 1'b0;
  assign selection_word = 1'b0;
  assign done = vld[Latency-1];
  assign word_pos_x   = pass[Latency-1][127:96];
  assign word_pos_y   = pass[Latency-1][95:64];
  assign word_pos_z   = pass[Latency-1][63:32];
  assign packed_color = pass[Latency-1][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Latency-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    pass[0] <= {pos_x, pos_y, pos_z, color_rgba};
    for (int i = 1; i < Latency; i++) begin
      pass[i] <= pass[i-1];
    end
    scl[0] <= {scale_x, scale_y, scale_z};
    for (int i = 1; i < ScaleTap; i++) begin
      scl[i] <= scl[i-1];
    end
    for (int t = 0; t < 6; t++) begin
      pd0[t] <= l6[t*3+2];
      pd1[t] <= pd0[t];
      pd2[t] <= pd1[t];
    end
    cov_xx_xy <= {to_half(l8[1]), to_half(l8[0])};
    cov_xz_yy <= {to_half(l8[3]), to_half(l8[2])};
    cov_yz_zz <= {to_half(l8[5]), to_half(l8[4])};
  end

  // Level 1 products, in order: xx yy zz xy xz yz wx wy wz.
  always_comb begin
    l1a = '{rot_x, rot_y, rot_z, rot_x, rot_x, rot_y, rot_w, rot_w, rot_w};
    l1b = '{rot_x, rot_y, rot_z, rot_y, rot_z, rot_z, rot_x, rot_y, rot_z};
  end

  // Rotation sums, indexed column * 3 + row; subtraction flips the sign.
  always_comb begin
    l2a = '{l1[1], l1[3], l1[4], l1[3], l1[0], l1[5], l1[4], l1[5], l1[0]};
    l2b = '{l1[2], l1[8], f32_neg(l1[7]), f32_neg(l1[8]), l1[2], l1[6],
            l1[7], f32_neg(l1[6]), l1[1]};
  end

  // Diagonal terms become one minus the doubled sum. Off-diagonal terms add
  // negative zero, which leaves every value unchanged and keeps the timing.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (k == 0 || k == 4 || k == 8) begin
        l4a[k] = F32_ONE;
        l4b[k] = f32_neg(l3[k]);
      end else begin
        l4a[k] = l3[k];
        l4b[k] = F32_NEG_ZERO;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      l5b[k]   = scl[ScaleTap-1][95:64];
      l5b[k+3] = scl[ScaleTap-1][63:32];
      l5b[k+6] = scl[ScaleTap-1][31:0];
    end
  end

  always_comb begin
    for (int t = 0; t < 6; t++) begin
      for (int c = 0; c < 3; c++) begin
        l6a[t*3+c] = l5[c*3+TermI[t]];
        l6b[t*3+c] = l5[c*3+TermJ[t]];
      end
      l7a[t] = l6[t*3];
      l7b[t] = l6[t*3+1];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_rot
    gcp_fmul u_l1 (.clk(clk), .a(l1a[k]), .b(l1b[k]), .y(l1[k]));
    gcp_fadd u_l2 (.clk(clk), .a(l2a[k]), .b(l2b[k]), .y(l2[k]));
    gcp_fmul u_l3 (.clk(clk), .a(l2[k]), .b(F32_TWO), .y(l3[k]));
    gcp_fadd u_l4 (.clk(clk), .a(l4a[k]), .b(l4b[k]), .y(l4[k]));
    gcp_fmul u_l5 (.clk(clk), .a(l4[k]), .b(l5b[k]), .y(l5[k]));
  end

  for (genvar k = 0; k < 18; k++) begin : g_prod
    gcp_fmul u_l6 (.clk(clk), .a(l6a[k]), .b(l6b[k]), .y(l6[k]));
  end

  for (genvar t = 0; t < 6; t++) begin : g_sum
    gcp_fadd u_l7 (.clk(clk), .a(l7a[t]), .b(l7b[t]), .y(l7[t]));
    gcp_fadd u_l8 (.clk(clk), .a(l7[t]), .b(pd2[t]), .y(l8[t]));
  end

endmodule
`default_nettype wire
